FILE: rtl/hcbc_pkg.sv
// Package: types, constants and a size clamp function for the color blob centroid tracker
`timescale 1ns / 1ps
package hcbc_pkg;

  localparam int MAX_COLS  = 4096;
  localparam int MAX_ROWS  = 4096;
  localparam int FRAC_BITS = 16;

  localparam int POS_W   = 12;
  localparam int CNT_W   = 25;
  localparam int SUM_W   = 37;
  localparam int SIZE_W  = 13;
  localparam int ADDR_W  = 5;
  localparam int DIVQ_W  = 37;
  localparam int DIVD_W  = 25;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W  = 2;

  localparam logic [ADDR_W-1:0] REG_WIDTH    = 5'd0;
  localparam logic [ADDR_W-1:0] REG_HEIGHT   = 5'd4;
  localparam logic [ADDR_W-1:0] REG_HUE_LOW  = 5'd8;
  localparam logic [ADDR_W-1:0] REG_HUE_HIGH = 5'd12;
  localparam logic [ADDR_W-1:0] REG_SAT_LOW  = 5'd16;
  localparam logic [ADDR_W-1:0] REG_SAT_HIGH = 5'd20;
  localparam logic [ADDR_W-1:0] REG_VAL_LOW  = 5'd24;
  localparam logic [ADDR_W-1:0] REG_VAL_HIGH = 5'd28;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       frame_start;
  } pixel_t;

  typedef struct packed {
    logic [11:0] mean_x;
    logic [11:0] mean_y;
    logic [15:0] center_x_frac;
    logic [15:0] center_y_frac;
    logic [24:0] hit_count;
    logic        found;
  } result_t;

  typedef struct packed {
    logic [SIZE_W-1:0] frame_width;
    logic [SIZE_W-1:0] frame_height;
    logic [7:0] hue_low;
    logic [7:0] hue_high;
    logic [7:0] sat_low;
    logic [7:0] sat_high;
    logic [7:0] val_low;
    logic [7:0] val_high;
  } cfg_t;

  // one frame's totals handed from the front to the divider back end
  typedef struct packed {
    logic [SUM_W-1:0]  sum_x;
    logic [SUM_W-1:0]  sum_y;
    logic [CNT_W-1:0]  count;
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
  } totals_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_DIV_X, BK_DIV_Y, BK_FRAC_X, BK_FRAC_Y, BK_OUT
  } back_state_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] x,
                                                   input int top);
    if (x == '0) return SIZE_W'(1);
    if (int'(x) > top) return SIZE_W'(top);
    return x;
  endfunction

endpackage

FILE: rtl/hcbc_front.sv
// Front end: HSV classification pipeline, position tracking and accumulation
`timescale 1ns / 1ps
module hcbc_front (
  input  logic            clk,
  input  logic            rst,
  input  hcbc_pkg::cfg_t  cfg,
  input  logic            valid,
  output logic            stall,
  input  hcbc_pkg::pixel_t pixel,
  output logic            tot_valid,
  input  logic            tot_full,
  output hcbc_pkg::totals_t totals
);
  import hcbc_pkg::*;

  // stage 1: max/min/diff and table lookups
  logic        s1_valid;
  logic        s1_start;
  logic [7:0]  s1_v, s1_diff;
  logic signed [11:0] s1_h;
  logic [19:0] s1_sdiv;
  logic [16:0] s1_hdiv;

  // stage 2: products
  logic        s2_valid;
  logic        s2_start;
  logic [7:0]  s2_v;
  logic [27:0] s2_sprod;
  logic signed [29:0] s2_hprod;

  logic [7:0]  mx, mn, df;
  logic signed [11:0] hc;
  logic [8:0]  sat_w;
  logic signed [29:0] hr;
  logic signed [15:0] hq;
  logic [7:0]  hue8;
  logic        pass;

  logic [POS_W-1:0] column_pos, row_pos;
  logic [CNT_W-1:0] pass_count;
  logic [SUM_W-1:0] sum_x, sum_y;
  logic [SIZE_W-1:0] w, hgt;
  logic [POS_W-1:0] col_base, row_base;
  logic [CNT_W-1:0] cnt_base;
  logic [SUM_W-1:0] sx_base, sy_base;
  logic [CNT_W-1:0] cnt_new;
  logic [SUM_W-1:0] sx_new, sy_new;
  logic last_col, last_row;

  // reciprocal tables: round(255<<12 / v) and round(180<<12 / 6d), ties to even
  logic [19:0] sdiv_rom [256];
  logic [16:0] hdiv_rom [256];

  for (genvar gi = 0; gi < 256; gi++) begin : g_rom
    localparam int SDEN = (gi == 0) ? 1 : gi;
    localparam int SQ   = (255 * 4096) / SDEN;
    localparam int SR   = (255 * 4096) % SDEN;
    localparam int SRND = ((2 * SR > SDEN) || ((2 * SR == SDEN) && ((SQ & 1) == 1))) ?
                          SQ + 1 : SQ;
    localparam int HDEN = (gi == 0) ? 6 : 6 * gi;
    localparam int HQ   = (180 * 4096) / HDEN;
    localparam int HR   = (180 * 4096) % HDEN;
    localparam int HRND = ((2 * HR > HDEN) || ((2 * HR == HDEN) && ((HQ & 1) == 1))) ?
                          HQ + 1 : HQ;
    assign sdiv_rom[gi] = (gi == 0) ? 20'd0 : 20'(SRND);
    assign hdiv_rom[gi] = (gi == 0) ? 17'd0 : 17'(HRND);
  end

  // the totals queue must be empty before a pixel enters, so every frame end in flight can land
  assign stall = tot_full;

  always_comb begin
    mx = pixel.blue;
    mn = pixel.blue;
    if (pixel.green > mx) mx = pixel.green;
    if (pixel.red > mx) mx = pixel.red;
    if (pixel.green < mn) mn = pixel.green;
    if (pixel.red < mn) mn = pixel.red;
    df = mx - mn;
    if (mx == pixel.red)
      hc = $signed({4'b0, pixel.green}) - $signed({4'b0, pixel.blue});
    else if (mx == pixel.green)
      hc = $signed({4'b0, pixel.blue}) - $signed({4'b0, pixel.red})
           + $signed({3'b0, df, 1'b0});
    else
      hc = $signed({4'b0, pixel.red}) - $signed({4'b0, pixel.green})
           + $signed({2'b0, df, 2'b0});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= valid && !stall;
      s2_valid <= s1_valid;
    end
    s1_start <= pixel.frame_start;
    s1_v     <= mx;
    s1_diff  <= df;
    s1_h     <= hc;
    s1_sdiv  <= sdiv_rom[mx];
    s1_hdiv  <= hdiv_rom[df];
    s2_start <= s1_start;
    s2_v     <= s1_v;
    s2_sprod <= 28'(s1_diff) * 28'(s1_sdiv);
    s2_hprod <= 30'(s1_h) * 30'($signed({1'b0, s1_hdiv}));
  end

  always_comb begin
    sat_w = 9'((s2_sprod + 28'd2048) >> 12);
    hr = s2_hprod + 30'sd2048;
    hq = 16'(hr >>> 12);
    if (hq < 0) hq = hq + 16'sd180;
    hue8 = hq[7:0];
    pass = (hue8 >= cfg.hue_low) && (hue8 <= cfg.hue_high) &&
           (sat_w >= {1'b0, cfg.sat_low}) && (sat_w <= {1'b0, cfg.sat_high}) &&
           (s2_v >= cfg.val_low) && (s2_v <= cfg.val_high);
  end

  always_comb begin
    w   = clamp_size(cfg.frame_width, MAX_COLS);
    hgt = clamp_size(cfg.frame_height, MAX_ROWS);
    col_base = s2_start ? '0 : column_pos;
    row_base = s2_start ? '0 : row_pos;
    cnt_base = s2_start ? '0 : pass_count;
    sx_base  = s2_start ? '0 : sum_x;
    sy_base  = s2_start ? '0 : sum_y;
    cnt_new = cnt_base + CNT_W'(pass);
    sx_new  = pass ? sx_base + SUM_W'(col_base) : sx_base;
    sy_new  = pass ? sy_base + SUM_W'(row_base) : sy_base;
    last_col = ({1'b0, col_base} + 1'b1) >= w;
    last_row = ({1'b0, row_base} + 1'b1) >= hgt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos <= '0;
      row_pos    <= '0;
      pass_count <= '0;
      sum_x      <= '0;
      sum_y      <= '0;
      tot_valid  <= 1'b0;
    end else begin
      tot_valid <= 1'b0;
      if (s2_valid) begin
        if (!last_col) begin
          column_pos <= col_base + 1'b1;
          row_pos    <= row_base;
          pass_count <= cnt_new;
          sum_x      <= sx_new;
          sum_y      <= sy_new;
        end else if (!last_row) begin
          column_pos <= '0;
          row_pos    <= row_base + 1'b1;
          pass_count <= cnt_new;
          sum_x      <= sx_new;
          sum_y      <= sy_new;
        end else begin
          column_pos <= '0;
          row_pos    <= '0;
          pass_count <= '0;
          sum_x      <= '0;
          sum_y      <= '0;
          tot_valid  <= 1'b1;
        end
      end
    end
    totals.sum_x  <= sx_new;
    totals.sum_y  <= sy_new;
    totals.count  <= cnt_new;
    totals.width  <= w;
    totals.height <= hgt;
  end
endmodule

FILE: rtl/hcbc_queue.sv
// Small FIFO of frame totals between the front end and the divider
`timescale 1ns / 1ps
module hcbc_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  hcbc_pkg::totals_t wr_data,
  output logic              full,
  output logic              rd_valid,
  input  logic              rd_en,
  output hcbc_pkg::totals_t rd_data
);
  import hcbc_pkg::*;

  totals_t slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   fill;
  logic do_rd;

  assign do_rd    = rd_en && (fill != '0);
  assign rd_valid = fill != '0;
  assign rd_data  = slots[rd_ptr];
  // headroom for the three pixels in the front pipeline plus the one taken now
  assign full     = fill >= (QPTR_W+1)'(QUEUE_DEPTH - 3);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (QPTR_W+1)'(wr_en) - (QPTR_W+1)'(do_rd);
    end
    if (wr_en) slots[wr_ptr] <= wr_data;
  end
endmodule

FILE: rtl/hcbc_divider.sv
// Restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module hcbc_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [hcbc_pkg::DIVQ_W-1:0] dividend,
  input  logic [hcbc_pkg::DIVD_W-1:0] divisor,
  output logic                        done,
  output logic [hcbc_pkg::DIVQ_W-1:0] quotient
);
  import hcbc_pkg::*;

  logic [DIVD_W:0]   rem;
  logic [DIVD_W+1:0] trial;
  logic [DIVD_W-1:0] dvs;
  logic [5:0]        cnt;
  logic              busy;

  assign trial = {rem, quotient[DIVQ_W-1]} - {2'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 6'(DIVQ_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
      dvs      <= divisor;
      cnt      <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (!trial[DIVD_W+1]) begin
        rem      <= trial[DIVD_W:0];
        quotient <= {quotient[DIVQ_W-2:0], 1'b1};
      end else begin
        rem      <= {rem[DIVD_W-1:0], quotient[DIVQ_W-1]};
        quotient <= {quotient[DIVQ_W-2:0], 1'b0};
      end
    end
  end
endmodule

FILE: rtl/hcbc_back.sv
// Back end: per-frame division sequence and result output register
`timescale 1ns / 1ps
module hcbc_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              tot_valid,
  output logic              tot_take,
  input  hcbc_pkg::totals_t totals,
  output logic              valid,
  input  logic              stall,
  output hcbc_pkg::result_t result
);
  import hcbc_pkg::*;

  back_state_t state, state_next;
  logic div_start, div_done;
  logic [DIVQ_W-1:0] dividend, quotient;
  logic [DIVD_W-1:0] divisor;
  totals_t cur;
  logic [11:0] mx, my;
  logic go;

  hcbc_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(dividend),
    .divisor(divisor), .done(div_done), .quotient(quotient)
  );

  assign go = (state == BK_IDLE) && tot_valid && (!valid || !stall);

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE:   if (go) state_next = (totals.count == '0) ? BK_OUT : BK_DIV_X;
      BK_DIV_X:  if (div_done) state_next = BK_DIV_Y;
      BK_DIV_Y:  if (div_done) state_next = BK_FRAC_X;
      BK_FRAC_X: if (div_done) state_next = BK_FRAC_Y;
      BK_FRAC_Y: if (div_done) state_next = BK_OUT;
      BK_OUT:    state_next = BK_IDLE;
      default:   state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    tot_take  = go;
    div_start = 1'b0;
    dividend  = '0;
    divisor   = '0;
    case (state)
      BK_IDLE: begin
        div_start = go && (totals.count != '0);
        dividend  = totals.sum_x;
        divisor   = totals.count;
      end
      BK_DIV_X: begin
        div_start = div_done;
        dividend  = cur.sum_y;
        divisor   = cur.count;
      end
      BK_DIV_Y: begin
        div_start = div_done;
        dividend  = DIVQ_W'({mx, FRAC_BITS'(0)});
        divisor   = DIVD_W'(cur.width);
      end
      BK_FRAC_X: begin
        div_start = div_done;
        dividend  = DIVQ_W'({my, FRAC_BITS'(0)});
        divisor   = DIVD_W'(cur.height);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      valid <= 1'b0;
    end else begin
      state <= state_next;
      if (valid && !stall) valid <= 1'b0;
      if (state == BK_OUT) valid <= 1'b1;
    end
    if (go) begin
      cur <= totals;
      result <= '0;
    end
    if (state == BK_DIV_X && div_done) mx <= quotient[11:0];
    if (state == BK_DIV_Y && div_done) my <= quotient[11:0];
    if (state == BK_FRAC_X && div_done) result.center_x_frac <= quotient[15:0];
    if (state == BK_FRAC_Y && div_done) result.center_y_frac <= quotient[15:0];
    if (state == BK_OUT && cur.count != '0) begin
      result.mean_x    <= mx;
      result.mean_y    <= my;
      result.hit_count <= cur.count;
      result.found     <= 1'b1;
    end
  end
endmodule

FILE: rtl/hsv_color_blob_centroid.sv
// Top level: HSV color threshold blob centroid tracker
//
//   channel  direction  payload          handshake
//   pixel    in         pixel_t          pixel_valid / pixel_stall
//   result   out        result_t         result_valid / result_stall
//   apb      in/out     8 registers      psel penable pwrite pready
//
// One pixel per cycle while pixel_stall is low, through a three-stage classify/accumulate
// front end; a frame's totals enter the queue from the accumulator registers and are taken
// once the back end is idle and holds no unaccepted result. The back end then runs four
// serial divides (none for a frame with no hits) and registers the result.
// Reset (rst, synchronous) restores register defaults and clears position and sums.
// pixel_stall is high while a totals entry waits; result_stall holds the result.
`timescale 1ns / 1ps
module hsv_color_blob_centroid (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pixel_valid,
  output logic                          pixel_stall,
  input  hcbc_pkg::pixel_t              pixel,
  output logic                          result_valid,
  input  logic                          result_stall,
  output hcbc_pkg::result_t             result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hcbc_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import hcbc_pkg::*;

  cfg_t cfg;
  logic tot_valid, tot_full, q_valid, q_take;
  totals_t tot_in, tot_out;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width  <= SIZE_W'(640);
      cfg.frame_height <= SIZE_W'(480);
      cfg.hue_low  <= 8'd38;
      cfg.hue_high <= 8'd79;
      cfg.sat_low  <= 8'd85;
      cfg.sat_high <= 8'd255;
      cfg.val_low  <= 8'd50;
      cfg.val_high <= 8'd255;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        REG_WIDTH:    cfg.frame_width  <= pwdata[SIZE_W-1:0];
        REG_HEIGHT:   cfg.frame_height <= pwdata[SIZE_W-1:0];
        REG_HUE_LOW:  cfg.hue_low  <= pwdata[7:0];
        REG_HUE_HIGH: cfg.hue_high <= pwdata[7:0];
        REG_SAT_LOW:  cfg.sat_low  <= pwdata[7:0];
        REG_SAT_HIGH: cfg.sat_high <= pwdata[7:0];
        REG_VAL_LOW:  cfg.val_low  <= pwdata[7:0];
        REG_VAL_HIGH: cfg.val_high <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      REG_WIDTH:    prdata = 32'(cfg.frame_width);
      REG_HEIGHT:   prdata = 32'(cfg.frame_height);
      REG_HUE_LOW:  prdata = 32'(cfg.hue_low);
      REG_HUE_HIGH: prdata = 32'(cfg.hue_high);
      REG_SAT_LOW:  prdata = 32'(cfg.sat_low);
      REG_SAT_HIGH: prdata = 32'(cfg.sat_high);
      REG_VAL_LOW:  prdata = 32'(cfg.val_low);
      REG_VAL_HIGH: prdata = 32'(cfg.val_high);
      default:      prdata = '0;
    endcase
  end

  hcbc_front u_front (
    .clk(clk), .rst(rst), .cfg(cfg), .valid(pixel_valid), .stall(pixel_stall),
    .pixel(pixel), .tot_valid(tot_valid), .tot_full(tot_full), .totals(tot_in)
  );

  hcbc_queue u_queue (
    .clk(clk), .rst(rst), .wr_en(tot_valid), .wr_data(tot_in), .full(tot_full),
    .rd_valid(q_valid), .rd_en(q_take), .rd_data(tot_out)
  );

  hcbc_back u_back (
    .clk(clk), .rst(rst), .tot_valid(q_valid), .tot_take(q_take), .totals(tot_out),
    .valid(result_valid), .stall(result_stall), .result(result)
  );
endmodule

FILE: sim/tb_hsv_color_blob_centroid.sv
// Testbench for the HSV color blob centroid tracker: table, random frames, scoreboard
`timescale 1ns / 1ps
module tb_hsv_color_blob_centroid;
  import hcbc_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE      = 400;

  logic clk, rst;
  logic pixel_valid, pixel_stall, result_valid, result_stall;
  pixel_t pixel;
  result_t result;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;

  hsv_color_blob_centroid dut (.*);

  typedef struct {
    pixel_t  pix;
    bit      typed;
    result_t res;
  } stim_row_t;

  // model copy of registers and frame state
  logic [SIZE_W-1:0] m_width, m_height;
  logic [7:0] m_hlo, m_hhi, m_slo, m_shi, m_vlo, m_vhi;
  int     m_col, m_row;
  longint m_cnt, m_sx, m_sy;

  result_t centroid_q[$];
  int errors, cycles, hold_len, snd_idle, rcv_idle, pixels_sent, results_seen;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint round_even(longint num, longint den);
    longint q, r;
    q = num / den;
    r = num % den;
    if (2 * r > den || (2 * r == den && q[0])) q++;
    return q;
  endfunction

  function automatic bit hsv_in_bounds(int b, int g, int r);
    int v, vmin, d, h, s;
    longint sd, hd, hh;
    v = b; vmin = b;
    if (g > v) v = g;
    if (r > v) v = r;
    if (g < vmin) vmin = g;
    if (r < vmin) vmin = r;
    d = v - vmin;
    sd = v ? round_even(255 * 4096, v) : 0;
    hd = d ? round_even(180 * 4096, 6 * d) : 0;
    s = int'((d * sd + 2048) >>> 12);
    if (v == r) h = g - b;
    else if (v == g) h = b - r + 2 * d;
    else h = r - g + 4 * d;
    hh = (h * hd + 2048) >>> 12;
    if (hh < 0) hh += 180;
    return hh >= m_hlo && hh <= m_hhi && s >= m_slo && s <= m_shi &&
           v >= m_vlo && v <= m_vhi;
  endfunction

  function automatic int size_clamp(logic [SIZE_W-1:0] x, int top);
    if (x == 0) return 1;
    if (x > top) return top;
    return x;
  endfunction

  function automatic void restart_frame();
    m_col = 0; m_row = 0; m_cnt = 0; m_sx = 0; m_sy = 0;
  endfunction

  function automatic void predict_centroid(pixel_t p);
    int w, h;
    longint mx, my;
    result_t res;
    w = size_clamp(m_width, MAX_COLS);
    h = size_clamp(m_height, MAX_ROWS);
    if (p.frame_start) restart_frame();
    if (hsv_in_bounds(p.blue, p.green, p.red)) begin
      m_cnt++; m_sx += m_col; m_sy += m_row;
    end
    if (m_col + 1 < w) begin
      m_col++;
      return;
    end
    m_col = 0;
    if (m_row + 1 < h) begin
      m_row++;
      return;
    end
    res = '0;
    if (m_cnt != 0) begin
      mx = m_sx / m_cnt;
      my = m_sy / m_cnt;
      res.mean_x = mx[11:0];
      res.mean_y = my[11:0];
      res.center_x_frac = 16'((mx << FRAC_BITS) / w);
      res.center_y_frac = 16'((my << FRAC_BITS) / h);
      res.hit_count = m_cnt[24:0];
      res.found = 1'b1;
    end
    centroid_q.insert(centroid_q.size(), res);
    restart_frame();
  endfunction

  task automatic cfg_write(logic [ADDR_W-1:0] addr, logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (addr)
      REG_WIDTH:    m_width  = val[SIZE_W-1:0];
      REG_HEIGHT:   m_height = val[SIZE_W-1:0];
      REG_HUE_LOW:  m_hlo = val[7:0];
      REG_HUE_HIGH: m_hhi = val[7:0];
      REG_SAT_LOW:  m_slo = val[7:0];
      REG_SAT_HIGH: m_shi = val[7:0];
      REG_VAL_LOW:  m_vlo = val[7:0];
      REG_VAL_HIGH: m_vhi = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_bounds(int hl, int hh, int sl, int sh, int vl, int vh);
    cfg_write(REG_HUE_LOW, hl);  cfg_write(REG_HUE_HIGH, hh);
    cfg_write(REG_SAT_LOW, sl);  cfg_write(REG_SAT_HIGH, sh);
    cfg_write(REG_VAL_LOW, vl);  cfg_write(REG_VAL_HIGH, vh);
  endtask

  task automatic send_pixel(pixel_t p);
    while ($urandom_range(99) < snd_idle) begin
      pixel_valid <= 0;
      @(posedge clk);
    end
    pixel_valid <= 1;
    pixel <= p;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    predict_centroid(p);
    pixels_sent++;
  endtask

  // pause the sender until every result is back, then let the back end settle
  task automatic drain();
    pixel_valid <= 0;
    while (centroid_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic pixel_t rand_pixel(bit fs);
    pixel_t p;
    p.blue = $urandom; p.green = $urandom; p.red = $urandom;
    p.frame_start = fs;
    return p;
  endfunction

  task automatic random_phase(int n_items);
    int w, h, stop, hl, sl, vl;
    pixel_t p;
    stop = pixels_sent + n_items;
    while (pixels_sent < stop) begin
      drain();
      w = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
      h = ($urandom_range(9) == 0) ? $urandom_range(8) : $urandom_range(5);
      cfg_write(REG_WIDTH, w);
      cfg_write(REG_HEIGHT, h);
      case ($urandom_range(4))
        0: set_bounds(0, 255, 0, 255, 0, 255);
        1: set_bounds($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        default: begin
          hl = $urandom_range(179); sl = $urandom_range(200); vl = $urandom_range(200);
          set_bounds(hl, hl + $urandom_range(90), sl, sl + $urandom_range(255 - sl),
                     vl, vl + $urandom_range(255 - vl));
        end
      endcase
      repeat ($urandom_range(4, 1)) begin
        for (int i = 0; i < size_clamp(w, MAX_COLS) * size_clamp(h, MAX_ROWS); i++) begin
          p = rand_pixel(i == 0 ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0));
          send_pixel(p);
        end
      end
    end
  endtask

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 0;
    end else if (hold_len > 0) begin
      result_stall <= 1;
      hold_len <= hold_len - 1;
    end else begin
      result_stall <= ($urandom_range(99) < rcv_idle);
    end
  end

  // scoreboard
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (centroid_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %p", $time, result);
      end else begin
        result_t e;
        e = centroid_q.pop_front();
        if (result.mean_x !== e.mean_x || result.mean_y !== e.mean_y ||
            result.center_x_frac !== e.center_x_frac ||
            result.center_y_frac !== e.center_y_frac ||
            result.hit_count !== e.hit_count || result.found !== e.found) begin
          errors++;
          $display("%0t: mismatch expected %p actual %p", $time, e, result);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  stim_row_t dir_rows[$];

  initial begin
    rst = 1; pixel_valid = 0; pixel = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    errors = 0; cycles = 0; hold_len = 0; snd_idle = 0; rcv_idle = 0;
    pixels_sent = 0; results_seen = 0;
    m_width = 640; m_height = 480;
    m_hlo = 38; m_hhi = 79; m_slo = 85; m_shi = 255; m_vlo = 50; m_vhi = 255;
    restart_frame();
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // single-pixel frames under the reset bounds
    cfg_write(REG_WIDTH, 1);
    cfg_write(REG_HEIGHT, 1);
    dir_rows = '{
      '{'{8'd0, 8'd255, 8'd0, 1'b1}, 1, '{12'd0, 12'd0, 16'd0, 16'd0, 25'd1, 1'b1}},
      '{'{8'd0, 8'd0, 8'd0, 1'b1}, 1, '0},
      '{'{8'd255, 8'd255, 8'd255, 1'b0}, 1, '0},
      '{'{8'd0, 8'd0, 8'd255, 1'b1}, 0, '0},
      '{'{8'd255, 8'd0, 8'd0, 1'b1}, 0, '0},
      '{'{8'd255, 8'd255, 8'd0, 1'b0}, 0, '0},
      '{'{8'd0, 8'd255, 8'd255, 1'b1}, 0, '0},
      '{'{8'd255, 8'd0, 8'd255, 1'b1}, 0, '0},
      '{'{8'd40, 8'd200, 8'd90, 1'b1}, 0, '0},
      '{'{8'd1, 8'd51, 8'd1, 1'b0}, 0, '0},
      '{'{8'd200, 8'd210, 8'd20, 1'b1}, 0, '0},
      '{'{8'd128, 8'd127, 8'd1, 1'b1}, 0, '0}
    };
    foreach (dir_rows[i]) begin
      send_pixel(dir_rows[i].pix);
      if (dir_rows[i].typed) centroid_q[$] = dir_rows[i].res;
    end
    drain();

    // empty ranges reject everything
    set_bounds(200, 10, 0, 255, 0, 255);
    send_pixel('{8'd0, 8'd255, 8'd0, 1'b1});
    centroid_q[$] = '0;
    drain();
    set_bounds(0, 255, 0, 255, 0, 255);

    // zero size acts as one
    cfg_write(REG_WIDTH, 0);
    cfg_write(REG_HEIGHT, 0);
    send_pixel(rand_pixel(1));
    send_pixel(rand_pixel(0));
    drain();

    // oversized width saturates, then a shrink ends the frame mid-row
    cfg_write(REG_WIDTH, 13'h1FFF);
    cfg_write(REG_HEIGHT, 1);
    for (int i = 0; i < 5; i++) send_pixel(rand_pixel(i == 0));
    drain();
    cfg_write(REG_WIDTH, 2);
    send_pixel(rand_pixel(0));
    drain();

    // row shrink: 8x4 frame cut down after ten pixels
    cfg_write(REG_WIDTH, 8);
    cfg_write(REG_HEIGHT, 4);
    for (int i = 0; i < 10; i++) send_pixel(rand_pixel(i == 0));
    drain();
    cfg_write(REG_WIDTH, 2);
    cfg_write(REG_HEIGHT, 2);
    send_pixel(rand_pixel(0));
    send_pixel(rand_pixel(0));
    drain();

    // receiver holds off long enough to back up the totals queue
    cfg_write(REG_WIDTH, 1);
    cfg_write(REG_HEIGHT, 1);
    hold_len = 3000;
    for (int i = 0; i < 20; i++) send_pixel(rand_pixel($urandom_range(1)));
    drain();

    snd_idle = 36; rcv_idle = 57;
    random_phase(280);
    snd_idle = 57; rcv_idle = 36;
    random_phase(280);
    snd_idle = 0; rcv_idle = 0;
    random_phase(280);
    drain();

    $display("Sent %0d pixels, checked %0d centroid results over directed and random frames",
             pixels_sent, results_seen);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
